// ----- src/wfes_pkg.sv -----
package wfes_pkg;

	// build-time defaults
	localparam int SEED_DEPTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;

	// most results one item may cause; also caps the seed buffer
	localparam int OUT_LIMIT = 16;

	// field and port widths
	localparam int RAW_W       = 16;
	localparam int OUT_W       = 33;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 40;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 16;
	localparam int INIT_W      = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 16;

	// register map
	localparam logic [CFG_IDX_W-1:0] REG_EMA_GAIN   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'b1;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd11880;
	localparam logic [INIT_W-1:0] INIT_RESET = 5'd15;

	// small-divisor divider: divisor width, quotient bits per cycle
	localparam int DVW      = 5;
	localparam int DIV_BITS = 8;
	localparam logic [DVW-1:0] BOX_TAPS = 5'd3;

	typedef struct packed {
		logic           start;
		logic [DVW-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic inexact;
	} div_rsp_t;

endpackage

// ----- src/wfes_div.sv -----
module wfes_div #(
	parameter int DW = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wfes_pkg::div_req_t  req,
	input  logic [DW-1:0]       dividend,
	output wfes_pkg::div_rsp_t  rsp,
	output logic [DW-1:0]       quotient
);

	localparam int STEPS = DW / wfes_pkg::DIV_BITS;
	localparam int CW    = $clog2(STEPS + 1);

	logic [DW-1:0]                quo_q;
	logic [wfes_pkg::DVW-1:0]     rem_q;
	logic [wfes_pkg::DVW-1:0]     dvs_q;
	logic [CW-1:0]                cnt_q;
	logic                         done_q;

	logic [wfes_pkg::DVW:0]       step_r;
	logic [DW-1:0]                step_q;

	// shift in one dividend bit per step, subtract where the remainder allows
	always_comb begin
		step_r = {1'b0, rem_q};
		step_q = quo_q;
		for (int k = 0; k < wfes_pkg::DIV_BITS; k++) begin
			step_r = {step_r[wfes_pkg::DVW-1:0], step_q[DW-1]};
			step_q = {step_q[DW-2:0], 1'b0};
			if (step_r >= {1'b0, dvs_q}) begin
				step_r    = step_r - {1'b0, dvs_q};
				step_q[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= CW'(STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			quo_q <= step_q;
			rem_q <= step_r[wfes_pkg::DVW-1:0];
		end
	end

	assign quotient    = quo_q;
	assign rsp.done    = done_q;
	assign rsp.inexact = (rem_q != '0);

endmodule

// ----- src/waveform_exp_box_smoother_unit.sv -----
// Channel  Dir  Handshake             Payload
// s_*      in   s_tvalid / s_tready   s_tdata: raw_sample; s_tlast: last_sample
// m_*      out  m_tvalid / m_tready   m_tdata: smoothed_value; m_tlast: last_output
// cfg_*    in   cfg_valid / cfg_ready cfg_index: register; cfg_data: value
//
// One item is in work at a time; s_tready is high only between items.
// A sample still filling the seed buffer is only stored. A live sample passes
// the multiply, add and emit states, one more emit for the closing 2-tap value,
// and the 3-tap divide once two averages exist.
// Seeding sums the n buffered samples, divides for their mean, then replays
// each buffered sample through the live-sample pass.
// Reset is asynchronous; a stalled m_tready holds the sequencer at its emit.
module waveform_exp_box_smoother_unit #(
	parameter int SEED_DEPTH = wfes_pkg::SEED_DEPTH_DEF,
	parameter int FRAC_BITS  = wfes_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wfes_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] raw_sample
	input  logic                              s_tlast,   // last_sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wfes_pkg::M_TDATA_W-1:0]    m_tdata,   // [32:0] smoothed_value, zero pad
	output logic                              m_tlast,   // last_output
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [wfes_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wfes_pkg::CFG_DATA_W-1:0]   cfg_data
);

	// effective buffer depth and derived widths
	localparam int ED    = (SEED_DEPTH < wfes_pkg::OUT_LIMIT) ? SEED_DEPTH
	                                                           : wfes_pkg::OUT_LIMIT;
	localparam int IW    = $clog2(ED);
	localparam int FW    = $clog2(ED + 1);
	localparam int SUM_W = wfes_pkg::RAW_W + IW;
	localparam int VW    = wfes_pkg::RAW_W + 1 + FRAC_BITS;
	localparam int PW    = VW + wfes_pkg::GAIN_W + 2;
	localparam int NEED  = (SUM_W > 18) ? SUM_W + FRAC_BITS : 18 + FRAC_BITS;
	localparam int DW    = ((NEED + wfes_pkg::DIV_BITS - 1) / wfes_pkg::DIV_BITS)
	                       * wfes_pkg::DIV_BITS;

	localparam logic [1:0] SEEN_NONE = 2'd0;
	localparam logic [1:0] SEEN_ONE  = 2'd1;
	localparam logic [1:0] SEEN_TWO  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_SEED_GO,
		S_SEED_WAIT,
		S_REP_RD,
		S_MUL,
		S_ADD,
		S_BOX_GO,
		S_BOX_WAIT,
		S_EMIT_A,
		S_EMIT_B,
		S_COMMIT
	} state_t;

	state_t state_q;

	// configuration
	logic [wfes_pkg::GAIN_W-1:0] gain_q;
	logic [wfes_pkg::INIT_W-1:0] init_q;

	// seed buffer and its read port
	logic [wfes_pkg::RAW_W-1:0] buf_q [ED];
	logic [wfes_pkg::RAW_W-1:0] rd_q;
	logic                       buf_we;

	// waveform control
	logic [FW-1:0] fill_q;
	logic [FW-1:0] cnt_q;
	logic          seeded_q;
	logic          rep_q;
	logic          last_q;
	logic          cur_last_q;
	logic          rd_vld_q;
	logic [1:0]    seen_q;

	// datapath
	logic [wfes_pkg::RAW_W-1:0] x_raw_q;
	logic [SUM_W-1:0]           sum_q;
	logic signed [VW-1:0]       cur_q;
	logic signed [VW-1:0]       prev_q;
	logic signed [VW-1:0]       y_q;
	logic signed [VW-1:0]       box_q;
	logic signed [PW-1:0]       prod_q;

	// output register
	logic                              out_vld_q;
	logic signed [wfes_pkg::OUT_W-1:0] out_val_q;
	logic                              out_last_q;

	logic          s_accept;
	logic          load_ok;
	logic [FW-1:0] fill_nx;
	logic [FW-1:0] lim;
	logic          trig;
	logic          more_rep;

	logic signed [VW-1:0] x_val;
	logic signed [VW:0]   diff;
	logic signed [16:0]   gain_s;
	logic signed [PW-1:0] prod_nx;
	logic signed [VW-1:0] y_nx;
	logic signed [VW:0]   s2;
	logic signed [VW-1:0] avg2;
	logic signed [VW+1:0] s3;
	logic [VW+1:0]        mag3;
	logic signed [VW-1:0] emit_a;
	logic                 last_a;
	logic                 need_a;

	wfes_pkg::div_req_t div_req;
	wfes_pkg::div_rsp_t div_rsp;
	logic [DW-1:0]      div_dividend;
	logic [DW-1:0]      div_quot;
	logic [DW:0]        div_qi;
	logic signed [VW-1:0] div_res;

	assign s_tready  = (state_q == S_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign load_ok   = !out_vld_q || m_tready;

	// seed count, clamped to the buffer and never below one
	always_comb begin
		if (init_q == '0) begin
			lim = FW'(1);
		end else if (init_q > wfes_pkg::INIT_W'(ED)) begin
			lim = FW'(ED);
		end else begin
			lim = FW'(init_q);
		end
	end

	assign buf_we   = s_accept && !seeded_q && (fill_q < FW'(ED));
	assign fill_nx  = (fill_q < FW'(ED)) ? FW'(fill_q + 1'b1) : fill_q;
	assign trig     = (fill_nx >= lim) || s_tlast;
	assign more_rep = rep_q && (cnt_q < fill_q);

	// moving average step: y = cur + floor(gain * (x - cur) / 2^16)
	assign x_val   = -$signed({1'b0, x_raw_q, {FRAC_BITS{1'b0}}});
	assign diff    = (VW+1)'(x_val) - (VW+1)'(cur_q);
	assign gain_s  = $signed({1'b0, gain_q});
	assign prod_nx = gain_s * diff;
	assign y_nx    = VW'((VW+1)'(cur_q) + (VW+1)'(prod_q >>> wfes_pkg::GAIN_FRAC));

	// two-tap and three-tap sums; all values are nonpositive
	assign s2   = (VW+1)'(cur_q) + (VW+1)'(y_q);
	assign avg2 = VW'(s2 >>> 1);
	assign s3   = (VW+2)'(prev_q) + (VW+2)'(cur_q) + (VW+2)'(y_q);
	assign mag3 = $unsigned(-s3);

	// floor of a negative quotient: negate the rounded-up magnitude
	assign div_qi  = (DW+1)'(div_quot) + (DW+1)'(div_rsp.inexact);
	assign div_res = $signed(VW'(-div_qi));

	always_comb begin
		div_req.start   = (state_q == S_SEED_GO) || (state_q == S_BOX_GO);
		div_req.divisor = wfes_pkg::BOX_TAPS;
		div_dividend    = DW'(mag3);
		if (state_q == S_SEED_GO) begin
			div_req.divisor = wfes_pkg::DVW'(fill_q);
			div_dividend    = DW'({sum_q, {FRAC_BITS{1'b0}}});
		end
	end

	wfes_div #(
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.rsp      (div_rsp),
		.quotient (div_quot)
	);

	// first result of a step: lone value on the first average, else a box average
	always_comb begin
		case (seen_q)
			SEEN_NONE: begin
				emit_a = y_q;
				last_a = 1'b1;
			end
			SEEN_ONE: begin
				emit_a = avg2;
				last_a = 1'b0;
			end
			default: begin
				emit_a = box_q;
				last_a = 1'b0;
			end
		endcase
	end
	assign need_a = (seen_q != SEEN_NONE) || cur_last_q;

	// seed buffer: write at the fill point, registered read at the sweep count
	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[fill_q[IW-1:0]] <= s_tdata[wfes_pkg::RAW_W-1:0];
		end
		rd_q <= buf_q[cnt_q[IW-1:0]];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (s_accept) begin
					x_raw_q <= s_tdata[wfes_pkg::RAW_W-1:0];
					sum_q   <= '0;
				end
			end
			S_SUM: begin
				if (rd_vld_q) begin
					sum_q <= sum_q + SUM_W'(rd_q);
				end
			end
			S_REP_RD:   x_raw_q <= rd_q;
			S_MUL:      prod_q  <= prod_nx;
			S_ADD:      y_q     <= y_nx;
			S_BOX_WAIT: begin
				if (div_rsp.done) begin
					box_q <= div_res;
				end
			end
			default: ;
		endcase
	end

	// sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			gain_q     <= wfes_pkg::GAIN_RESET;
			init_q     <= wfes_pkg::INIT_RESET;
			fill_q     <= '0;
			cnt_q      <= '0;
			seeded_q   <= 1'b0;
			rep_q      <= 1'b0;
			last_q     <= 1'b0;
			cur_last_q <= 1'b0;
			rd_vld_q   <= 1'b0;
			seen_q     <= SEEN_NONE;
			cur_q      <= '0;
			prev_q     <= '0;
			out_vld_q  <= 1'b0;
			out_val_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					wfes_pkg::REG_EMA_GAIN:   gain_q <= cfg_data;
					wfes_pkg::REG_INIT_COUNT: init_q <= cfg_data[wfes_pkg::INIT_W-1:0];
					default: ;
				endcase
			end

			// drop the held item once taken; a load below wins
			if (m_tready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						last_q <= s_tlast;
						if (seeded_q) begin
							cur_last_q <= s_tlast;
							state_q    <= S_MUL;
						end else begin
							fill_q <= fill_nx;
							if (trig) begin
								cnt_q    <= '0;
								rd_vld_q <= 1'b0;
								state_q  <= S_SUM;
							end
						end
					end
				end
				S_SUM: begin
					if (cnt_q < fill_q) begin
						cnt_q    <= cnt_q + 1'b1;
						rd_vld_q <= 1'b1;
					end else begin
						rd_vld_q <= 1'b0;
						if (!rd_vld_q) begin
							state_q <= S_SEED_GO;
						end
					end
				end
				S_SEED_GO: begin
					cnt_q   <= '0;
					state_q <= S_SEED_WAIT;
				end
				S_SEED_WAIT: begin
					if (div_rsp.done) begin
						cur_q    <= div_res;
						prev_q   <= '0;
						seen_q   <= SEEN_NONE;
						seeded_q <= 1'b1;
						rep_q    <= 1'b1;
						state_q  <= S_REP_RD;
					end
				end
				S_REP_RD: begin
					// replayed sample is last only at the end of the buffer
					cur_last_q <= last_q && (FW'(cnt_q + 1'b1) == fill_q);
					cnt_q      <= cnt_q + 1'b1;
					state_q    <= S_MUL;
				end
				S_MUL: state_q <= S_ADD;
				S_ADD: state_q <= (seen_q == SEEN_TWO) ? S_BOX_GO : S_EMIT_A;
				S_BOX_GO: state_q <= S_BOX_WAIT;
				S_BOX_WAIT: begin
					if (div_rsp.done) begin
						state_q <= S_EMIT_A;
					end
				end
				S_EMIT_A: begin
					if (!need_a) begin
						state_q <= S_COMMIT;
					end else if (load_ok) begin
						out_vld_q  <= 1'b1;
						out_val_q  <= wfes_pkg::OUT_W'(emit_a);
						out_last_q <= last_a;
						state_q    <= (cur_last_q && seen_q != SEEN_NONE) ? S_EMIT_B
						                                                  : S_COMMIT;
					end
				end
				S_EMIT_B: begin
					// closing 2-tap average of the waveform
					if (load_ok) begin
						out_vld_q  <= 1'b1;
						out_val_q  <= wfes_pkg::OUT_W'(avg2);
						out_last_q <= 1'b1;
						state_q    <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					prev_q <= cur_q;
					cur_q  <= y_q;
					seen_q <= (seen_q == SEEN_TWO) ? SEEN_TWO : seen_q + 2'd1;
					if (more_rep) begin
						state_q <= S_REP_RD;
					end else begin
						rep_q   <= 1'b0;
						state_q <= S_IDLE;
						if (last_q) begin
							fill_q   <= '0;
							seeded_q <= 1'b0;
							cur_q    <= '0;
							prev_q   <= '0;
							seen_q   <= SEEN_NONE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(wfes_pkg::M_TDATA_W - wfes_pkg::OUT_W){1'b0}}, out_val_q};
	assign m_tlast  = out_last_q;

	// the divider answers only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_SEED_WAIT || state_q == S_BOX_WAIT))
		else $error("divider result outside a wait state");

	// the end of a waveform clears the fill count, the seeded flag and the seen count
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMMIT && last_q && !more_rep)
		|=> (fill_q == '0 && !seeded_q && seen_q == SEEN_NONE))
		else $error("waveform state not cleared after last item");

	// a second result in one step only closes a waveform after an average exists
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT_B) |-> (cur_last_q && seen_q != SEEN_NONE))
		else $error("closing result without a last sample");

endmodule
